// ----- hw/rtl/clpot_pkg.sv -----
// Shared types and command codes for the shape-pair overlap test.
// No dependencies; imported by every module of the block.
package clpot_pkg;

	// Pair kinds carried by the command field
	localparam logic [1:0] CMD_SEG  = 2'd0;
	localparam logic [1:0] CMD_BOX  = 2'd1;
	localparam logic [1:0] CMD_CIRC = 2'd2;
	localparam logic [1:0] CMD_MIX  = 2'd3;

	// Strict box comparisons, one bit per bound
	typedef struct packed {
		logic x_lo;   // a min x < b max x
		logic x_hi;   // a max x > b min x
		logic y_lo;   // a min y < b max y
		logic y_hi;   // a max y > b min y
	} box_cmp_t;

endpackage

// ----- hw/rtl/clpot_prod.sv -----
// Product stage: coordinate differences, shared multipliers and box compares.
// Depends on clpot_pkg; registers its results into stage 2 when en is high.
module clpot_prod #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [1:0]                    cmd,
	input  logic signed [COORD_BITS-1:0]  a_x1,
	input  logic signed [COORD_BITS-1:0]  a_y1,
	input  logic signed [COORD_BITS-1:0]  a_x2,
	input  logic signed [COORD_BITS-1:0]  a_y2,
	input  logic [COORD_BITS-2:0]         a_radius,
	input  logic signed [COORD_BITS-1:0]  b_x1,
	input  logic signed [COORD_BITS-1:0]  b_y1,
	input  logic signed [COORD_BITS-1:0]  b_x2,
	input  logic signed [COORD_BITS-1:0]  b_y2,
	input  logic [COORD_BITS-2:0]         b_radius,
	output logic [1:0]                    cmd_s2,
	output clpot_pkg::box_cmp_t           box_s2,
	output logic signed [2*COORD_BITS+1:0] m0_s2,
	output logic signed [2*COORD_BITS+1:0] m1_s2,
	output logic signed [2*COORD_BITS+1:0] m2_s2,
	output logic signed [2*COORD_BITS+1:0] m3_s2,
	output logic signed [2*COORD_BITS+1:0] m4_s2,
	output logic signed [2*COORD_BITS+1:0] m5_s2
);
	import clpot_pkg::*;

	localparam int D = COORD_BITS + 1;   // difference width
	localparam int P = 2 * D;            // product width

	logic signed [D-1:0] dax, day, dbx, dby, ox, oy, rs;
	logic [COORD_BITS-1:0] rsum;
	logic signed [D-1:0] op0a, op0b, op1a, op1b, op2a, op2b;
	logic signed [P-1:0] m0_d, m1_d, m2_d, m3_d, m4_d, m5_d;
	logic is_circ;
	box_cmp_t box_d;

	// Segment directions and start offset, sign extended by one bit
	assign dax = $signed({a_x2[COORD_BITS-1], a_x2}) - $signed({a_x1[COORD_BITS-1], a_x1});
	assign day = $signed({a_y2[COORD_BITS-1], a_y2}) - $signed({a_y1[COORD_BITS-1], a_y1});
	assign dbx = $signed({b_x2[COORD_BITS-1], b_x2}) - $signed({b_x1[COORD_BITS-1], b_x1});
	assign dby = $signed({b_y2[COORD_BITS-1], b_y2}) - $signed({b_y1[COORD_BITS-1], b_y1});
	assign ox  = $signed({a_x1[COORD_BITS-1], a_x1}) - $signed({b_x1[COORD_BITS-1], b_x1});
	assign oy  = $signed({a_y1[COORD_BITS-1], a_y1}) - $signed({b_y1[COORD_BITS-1], b_y1});

	// Radius sum, never negative
	assign rsum = {1'b0, a_radius} + {1'b0, b_radius};
	assign rs   = $signed({1'b0, rsum});

	// Circle pairs borrow the first three multipliers for the squares
	assign is_circ = (cmd == CMD_CIRC);
	assign op0a = is_circ ? ox : dby;
	assign op0b = is_circ ? ox : dax;
	assign op1a = is_circ ? oy : dbx;
	assign op1b = is_circ ? oy : day;
	assign op2a = is_circ ? rs : dbx;
	assign op2b = is_circ ? rs : oy;

	assign m0_d = op0a * op0b;
	assign m1_d = op1a * op1b;
	assign m2_d = op2a * op2b;
	assign m3_d = dby * ox;
	assign m4_d = dax * oy;
	assign m5_d = day * ox;

	// Strict overlap on both axes
	assign box_d.x_lo = (a_x1 < b_x2);
	assign box_d.x_hi = (a_x2 > b_x1);
	assign box_d.y_lo = (a_y1 < b_y2);
	assign box_d.y_hi = (a_y2 > b_y1);

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd;
			box_s2 <= box_d;
			m0_s2  <= m0_d;
			m1_s2  <= m1_d;
			m2_s2  <= m2_d;
			m3_s2  <= m3_d;
			m4_s2  <= m4_d;
			m5_s2  <= m5_d;
		end
	end

endmodule

// ----- hw/rtl/clpot_decide.sv -----
// Decision logic: segment ratio checks, circle distance compare, box and.
// Depends on clpot_pkg; purely combinational, fed by the product stage.
module clpot_decide #(
	parameter int COORD_BITS = 16
) (
	input  logic [1:0]                     cmd,
	input  clpot_pkg::box_cmp_t            box,
	input  logic signed [2*COORD_BITS+1:0] m0,
	input  logic signed [2*COORD_BITS+1:0] m1,
	input  logic signed [2*COORD_BITS+1:0] m2,
	input  logic signed [2*COORD_BITS+1:0] m3,
	input  logic signed [2*COORD_BITS+1:0] m4,
	input  logic signed [2*COORD_BITS+1:0] m5,
	output logic                           hit
);
	import clpot_pkg::*;

	localparam int P = 2 * COORD_BITS + 2;   // product width
	localparam int W = P + 1;                // difference of products

	logic signed [W-1:0] den, nt, ns;
	logic signed [W-1:0] e0, e1, e2;
	logic [W-1:0] den_abs, nt_abs, ns_abs;
	logic nt_ok, ns_ok, seg_hit, box_hit, circ_hit;

	assign e0 = $signed({m0[P-1], m0});
	assign e1 = $signed({m1[P-1], m1});
	assign e2 = $signed({m2[P-1], m2});

	// Cross products: den = dby*dax - dbx*day, numerators likewise
	assign den = e0 - e1;
	assign nt  = e2 - $signed({m3[P-1], m3});
	assign ns  = $signed({m4[P-1], m4}) - $signed({m5[P-1], m5});

	assign den_abs = den[W-1] ? W'(-den) : W'(den);
	assign nt_abs  = nt[W-1]  ? W'(-nt)  : W'(nt);
	assign ns_abs  = ns[W-1]  ? W'(-ns)  : W'(ns);

	// Parameter in [0,1]: same sign as den (or zero) and no larger in magnitude
	assign nt_ok = !((nt != '0) && (nt[W-1] != den[W-1])) && (nt_abs <= den_abs);
	assign ns_ok = !((ns != '0) && (ns[W-1] != den[W-1])) && (ns_abs <= den_abs);

	// Parallel pairs and the both-numerators-zero case never hit
	assign seg_hit = (den != '0) && nt_ok && ns_ok && !((nt == '0) && (ns == '0));

	assign box_hit = box.x_lo && box.x_hi && box.y_lo && box.y_hi;

	// Squared distance against squared radius sum
	assign circ_hit = ((e0 + e1) < e2);

	always_comb begin
		unique case (cmd)
			CMD_SEG:  hit = seg_hit;
			CMD_BOX:  hit = box_hit;
			CMD_CIRC: hit = circ_hit;
			CMD_MIX:  hit = 1'b0;
			default:  hit = 1'b0;
		endcase
	end

endmodule

// ----- hw/rtl/collider_pair_overlap_test_unit.sv -----
// Top level of the shape-pair overlap test: input register, valid pipeline,
// result register. Depends on clpot_pkg, clpot_prod and clpot_decide.
//
// Usage:
//   Input channel (in_valid / in_stall) carries a command and two shapes
//   in world coordinates: two segments, two boxes, two circles, or a
//   mismatched pair. Output channel (out_valid / out_stall) returns one
//   hit bit per input transfer, in order.
//   Path: a transfer accepted into the input register moves on to the
//   product register and then to the result register before its result
//   shows on the output.
//   Throughput: one transfer per cycle while out_stall is low, set by the
//   three-stage pipeline; each stage holds one item, moving when the one ahead frees.
//   Stall: when out_stall holds, a full pipeline backs up and in_stall rises
//   in the same cycle; bubbles inside the pipeline are squeezed out first,
//   so up to three items are held while the receiver stalls.
//   Reset: arst_n low clears all valid flags; no result is shown and the
//   block accepts input in the first cycle after reset.
//   Coordinates are COORD_BITS wide, radii one bit narrower.
module collider_pair_overlap_test_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   command,
	input  logic signed [COORD_BITS-1:0] a_x1,
	input  logic signed [COORD_BITS-1:0] a_y1,
	input  logic signed [COORD_BITS-1:0] a_x2,
	input  logic signed [COORD_BITS-1:0] a_y2,
	input  logic [COORD_BITS-2:0]        a_radius,
	input  logic signed [COORD_BITS-1:0] b_x1,
	input  logic signed [COORD_BITS-1:0] b_y1,
	input  logic signed [COORD_BITS-1:0] b_x2,
	input  logic signed [COORD_BITS-1:0] b_y2,
	input  logic [COORD_BITS-2:0]        b_radius,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit
);
	import clpot_pkg::*;

	localparam int P = 2 * COORD_BITS + 2;

	logic v_s1, v_s2, out_valid_q, hit_q, hit_d;
	logic ld_s1, ld_s2, ld_s3;
	logic [1:0] cmd_s1, cmd_s2;
	logic signed [COORD_BITS-1:0] a_x1_s1, a_y1_s1, a_x2_s1, a_y2_s1;
	logic signed [COORD_BITS-1:0] b_x1_s1, b_y1_s1, b_x2_s1, b_y2_s1;
	logic [COORD_BITS-2:0] a_radius_s1, b_radius_s1;
	box_cmp_t box_s2;
	logic signed [P-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;

	// Stage load enables: a stage loads when empty or when it drains forward
	assign ld_s3    = !out_valid_q || !out_stall;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_stall = !ld_s1;

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= in_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) out_valid_q <= v_s2;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			cmd_s1      <= command;
			a_x1_s1     <= a_x1;
			a_y1_s1     <= a_y1;
			a_x2_s1     <= a_x2;
			a_y2_s1     <= a_y2;
			a_radius_s1 <= a_radius;
			b_x1_s1     <= b_x1;
			b_y1_s1     <= b_y1;
			b_x2_s1     <= b_x2;
			b_y2_s1     <= b_y2;
			b_radius_s1 <= b_radius;
		end
	end

	clpot_prod #(
		.COORD_BITS (COORD_BITS)
	) u_prod (
		.clk      (clk),
		.en       (ld_s2),
		.cmd      (cmd_s1),
		.a_x1     (a_x1_s1),
		.a_y1     (a_y1_s1),
		.a_x2     (a_x2_s1),
		.a_y2     (a_y2_s1),
		.a_radius (a_radius_s1),
		.b_x1     (b_x1_s1),
		.b_y1     (b_y1_s1),
		.b_x2     (b_x2_s1),
		.b_y2     (b_y2_s1),
		.b_radius (b_radius_s1),
		.cmd_s2   (cmd_s2),
		.box_s2   (box_s2),
		.m0_s2    (m0_s2),
		.m1_s2    (m1_s2),
		.m2_s2    (m2_s2),
		.m3_s2    (m3_s2),
		.m4_s2    (m4_s2),
		.m5_s2    (m5_s2)
	);

	clpot_decide #(
		.COORD_BITS (COORD_BITS)
	) u_decide (
		.cmd (cmd_s2),
		.box (box_s2),
		.m0  (m0_s2),
		.m1  (m1_s2),
		.m2  (m2_s2),
		.m3  (m3_s2),
		.m4  (m4_s2),
		.m5  (m5_s2),
		.hit (hit_d)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (ld_s3) hit_q <= hit_d;
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

`ifndef SYNTHESIS
	// Input backs up only when every stage is full and the receiver stalls
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	// An accepted transfer occupies the input register next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted transfer lost at input register");

	// Stage 2 keeps its item while the result register is blocked
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && out_valid_q && out_stall) |=> v_s2)
		else $error("stage 2 item dropped during output stall");

	// Mismatched kinds always report no hit
	a_mix_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && ld_s3 && (cmd_s2 == CMD_MIX)) |=> !hit_q)
		else $error("mismatched pair reported a hit");

	// A delivered result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !v_s2) |=> !out_valid_q)
		else $error("result repeated after transfer");
`endif

endmodule
